// ===== hdl/xcfr_pkg.sv =====
// ---------------------------------------------------------------------------
// xcfr_pkg
// Shared types and constants for the XOR-checked frame receiver.
// ---------------------------------------------------------------------------
package xcfr_pkg;

    // Default depth of the frame byte store
    localparam int FRAME_DEPTH_DEFAULT = 32;

    // Hard cap on the length field
    localparam int LEN_CAP = 29;

    // Register reset values
    localparam logic [7:0] SYNC_RESET  = 8'hAA;
    localparam logic [7:0] END_RESET   = 8'hBB;
    localparam logic [4:0] LIMIT_RESET = 5'd24;

    // Register map (word index)
    typedef enum logic [1:0] {
        REG_SYNC  = 2'd0,
        REG_END   = 2'd1,
        REG_LIMIT = 2'd2,
        REG_NONE  = 2'd3
    } t_reg_idx;

    // Frame status codes
    typedef enum logic [1:0] {
        ST_GOOD      = 2'd0,
        ST_CHECKSUM  = 2'd1,
        ST_BAD_END   = 2'd2,
        ST_TOO_SHORT = 2'd3
    } t_status;

    // One result request
    typedef struct packed {
        logic [7:0] frame_byte;
        logic [4:0] byte_index;
        t_status    status;
        logic       is_last;
    } t_result;

endpackage

// ===== hdl/xor_checked_frame_receiver.sv =====
// ---------------------------------------------------------------------------
// xor_checked_frame_receiver
// Hunts for a sync byte, collects a length-prefixed frame into a byte store,
// checks the XOR checksum and end byte, then replays command and payload.
// ---------------------------------------------------------------------------
// Input: one byte per cycle while hunting and receiving and the queue has room.
// A good frame of N command/payload bytes replays from the store one byte
// per cycle while the queue has room; the first result passes the replay
// start, registered store read and queue; input is held until the last
// store read has returned. A bad frame gives one status result the cycle
// after the end byte. The result side is a two-entry queue, so input keeps
// flowing while it waits until full. Reset clears the hunt, replay and queue
// control and loads the register defaults; the byte store is not cleared.
module xor_checked_frame_receiver #(
    parameter int FRAME_DEPTH = xcfr_pkg::FRAME_DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_packet_start,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_frame_byte,
    output logic [4:0]  o_byte_index,
    output logic [1:0]  o_status,
    output logic        o_is_last,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW     = $clog2(FRAME_DEPTH);
    localparam int CapInt = (FRAME_DEPTH - 3 < xcfr_pkg::LEN_CAP) ?
                            (FRAME_DEPTH - 3) : xcfr_pkg::LEN_CAP;
    localparam logic [4:0] LenCap = 5'(CapInt);

    // Configuration registers
    logic [7:0] r_sync_byte;
    logic [7:0] r_end_byte;
    logic [4:0] r_length_limit;

    // Hunt and frame state
    logic [4:0] r_hp, n_hp;
    logic [4:0] r_br, n_br;
    logic [7:0] r_xor, n_xor;

    // Replay sequencer
    logic       r_rp_active, n_rp_active;
    logic [4:0] r_rp_idx, n_rp_idx;
    logic [4:0] r_rp_cnt, n_rp_cnt;

    // Store read in flight
    logic       r_rd_pend;
    logic [4:0] r_rd_idx;
    logic       r_rd_last;
    logic [7:0] r_rd_data;

    // Byte store
    logic [7:0] r_mem [FRAME_DEPTH];

    // Result queue
    xcfr_pkg::t_result r_q [2];
    logic              r_q_head;
    logic [1:0]        r_q_count, n_q_count;

    // Handshakes
    logic              in_acc;
    logic              out_pop;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic              rd_en;
    logic              push;
    xcfr_pkg::t_result push_item;
    logic              err_push;
    xcfr_pkg::t_result err_item;
    logic              q_tail;
    logic              cfg_wr;
    xcfr_pkg::t_reg_idx cfg_idx;

    // Frame datapath temporaries
    logic [4:0] hp_e, br_e;
    logic [7:0] xor_e;
    logic [4:0] lim;
    logic [4:0] body_pos;
    logic [4:0] frame_cnt;
    xcfr_pkg::t_status fin_status;
    logic [7:0] xor_upd;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign cfg_idx  = xcfr_pkg::t_reg_idx'(paddr[3:2]);

    // Hold input during replay, while a read is in flight, or on a full queue
    assign o_in_stall = r_rp_active | r_rd_pend | (r_q_count == 2'd2);
    assign in_acc     = i_in_valid & ~o_in_stall;

    assign o_out_valid  = (r_q_count != 2'd0);
    assign out_pop      = o_out_valid & ~i_out_stall;
    assign o_frame_byte = r_q[r_q_head].frame_byte;
    assign o_byte_index = r_q[r_q_head].byte_index;
    assign o_status     = r_q[r_q_head].status;
    assign o_is_last    = r_q[r_q_head].is_last;

    // Register read mux
    always_comb begin
        unique case (cfg_idx)
            xcfr_pkg::REG_SYNC:  prdata = {24'd0, r_sync_byte};
            xcfr_pkg::REG_END:   prdata = {24'd0, r_end_byte};
            xcfr_pkg::REG_LIMIT: prdata = {27'd0, r_length_limit};
            default:             prdata = 32'd0;
        endcase
    end

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte    <= xcfr_pkg::SYNC_RESET;
            r_end_byte     <= xcfr_pkg::END_RESET;
            r_length_limit <= xcfr_pkg::LIMIT_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                xcfr_pkg::REG_SYNC:  r_sync_byte    <= pwdata[7:0];
                xcfr_pkg::REG_END:   r_end_byte     <= pwdata[7:0];
                xcfr_pkg::REG_LIMIT: r_length_limit <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // Frame parser: restart on packet start, then advance one byte
    always_comb begin
        hp_e   = i_packet_start ? 5'd0 : r_hp;
        br_e   = i_packet_start ? 5'd0 : r_br;
        xor_e  = i_packet_start ? 8'd0 : r_xor;
        lim    = (r_length_limit > LenCap) ? LenCap : r_length_limit;
        body_pos  = hp_e - 5'd2;
        xor_upd   = xor_e ^ i_rx_byte;
        frame_cnt = (hp_e >= 5'd4) ? (hp_e - 5'd3) : 5'd0;

        // too short first, then checksum, then end byte
        if (frame_cnt == 5'd0) begin
            fin_status = xcfr_pkg::ST_TOO_SHORT;
        end else if (r_xor != 8'd0) begin
            fin_status = xcfr_pkg::ST_CHECKSUM;
        end else if (i_rx_byte != r_end_byte) begin
            fin_status = xcfr_pkg::ST_BAD_END;
        end else begin
            fin_status = xcfr_pkg::ST_GOOD;
        end
        if (i_packet_start) begin
            fin_status = xcfr_pkg::ST_TOO_SHORT;
        end

        n_hp        = r_hp;
        n_br        = r_br;
        n_xor       = r_xor;
        n_rp_active = r_rp_active;
        n_rp_idx    = r_rp_idx;
        n_rp_cnt    = r_rp_cnt;
        wr_en       = 1'b0;
        wr_addr     = AW'(body_pos);
        err_push    = 1'b0;
        err_item    = '{frame_byte: 8'd0, byte_index: 5'd0,
                        status: fin_status, is_last: 1'b1};
        rd_en       = 1'b0;

        if (in_acc) begin
            n_hp  = hp_e;
            n_br  = br_e;
            n_xor = xor_e;
            if (hp_e == 5'd0) begin
                if (i_rx_byte == r_sync_byte) begin
                    n_hp  = 5'd1;
                    n_xor = 8'd0;
                end
            end else if (hp_e == 5'd1) begin
                // clamp an oversize length to a checksum and end byte tail
                n_br  = (i_rx_byte > {3'd0, lim}) ? 5'd2 : (i_rx_byte[4:0] + 5'd1);
                n_xor = i_rx_byte;
                n_hp  = 5'd2;
            end else if (br_e > 5'd2) begin
                wr_en = 1'b1;
                n_xor = xor_upd;
                n_hp  = hp_e + 5'd1;
                n_br  = br_e - 5'd1;
            end else if (br_e == 5'd2) begin
                n_xor = xor_upd;
                n_hp  = hp_e + 5'd1;
                n_br  = br_e - 5'd1;
            end else if (br_e == 5'd1) begin
                // frame complete: report or start replay
                if (fin_status == xcfr_pkg::ST_GOOD) begin
                    n_rp_active = 1'b1;
                    n_rp_idx    = 5'd0;
                    n_rp_cnt    = frame_cnt;
                end else begin
                    err_push = 1'b1;
                end
                n_hp  = 5'd0;
                n_br  = 5'd0;
                n_xor = 8'd0;
            end else begin
                n_hp  = 5'd0;
                n_br  = 5'd0;
                n_xor = 8'd0;
            end
        end

        // Queue occupancy after this cycle
        push      = err_push | r_rd_pend;
        n_q_count = r_q_count + {1'b0, push} - {1'b0, out_pop};

        // Issue a store read only when the queue can take it next cycle
        if (r_rp_active && (n_q_count <= 2'd1)) begin
            rd_en    = 1'b1;
            n_rp_idx = r_rp_idx + 5'd1;
            if (r_rp_idx + 5'd1 == r_rp_cnt) begin
                n_rp_active = 1'b0;
            end
        end
    end

    assign q_tail = r_q_head ^ r_q_count[0];

    always_comb begin
        if (r_rd_pend) begin
            push_item = '{frame_byte: r_rd_data, byte_index: r_rd_idx,
                          status: xcfr_pkg::ST_GOOD, is_last: r_rd_last};
        end else begin
            push_item = err_item;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp        <= 5'd0;
            r_br        <= 5'd0;
            r_xor       <= 8'd0;
            r_rp_active <= 1'b0;
            r_rp_idx    <= 5'd0;
            r_rp_cnt    <= 5'd0;
            r_rd_pend   <= 1'b0;
            r_q_head    <= 1'b0;
            r_q_count   <= 2'd0;
        end else begin
            r_hp        <= n_hp;
            r_br        <= n_br;
            r_xor       <= n_xor;
            r_rp_active <= n_rp_active;
            r_rp_idx    <= n_rp_idx;
            r_rp_cnt    <= n_rp_cnt;
            r_rd_pend   <= rd_en;
            r_q_count   <= n_q_count;
            if (out_pop) begin
                r_q_head <= ~r_q_head;
            end
        end
    end

    // Read tag travels with the store read
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_idx  <= r_rp_idx;
            r_rd_last <= (r_rp_idx + 5'd1 == r_rp_cnt);
        end
    end

    // Byte store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_rx_byte;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[AW'(r_rp_idx)];
        end
    end

    // Queue payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[q_tail] <= push_item;
        end
    end

endmodule

// ===== tb/xor_checked_frame_receiver_tb.sv =====
// ---------------------------------------------------------------------------
// xor_checked_frame_receiver_tb
// Self-checking bench for the XOR-checked frame receiver. Streams sync, length,
// command, payload, checksum and end bytes under several register settings,
// predicts every replayed byte and status request, and compares the results
// field by field while both channels idle and stall at random, bar a full-rate run.
// ---------------------------------------------------------------------------
package xcfr_tb_pkg;
    import xcfr_pkg::*;

    class frame_deframer_model;
        logic [7:0] sync_val;
        logic [7:0] end_val;
        logic [4:0] limit_val;
        int         hunt_pos;
        int         bytes_due;
        logic [7:0] check_acc;
        logic [7:0] store [FRAME_DEPTH_DEFAULT];
        t_result    replay_queue [$];
        int         mismatches;

        function new();
            sync_val   = SYNC_RESET;
            end_val    = END_RESET;
            limit_val  = LIMIT_RESET;
            mismatches = 0;
            foreach (store[i]) store[i] = 8'h00;
            rearm_hunt();
        endfunction

        function void rearm_hunt();
            hunt_pos  = 0;
            bytes_due = 0;
            check_acc = 8'h00;
        endfunction

        // Length field ceiling after the hard cap and the store depth
        function int eff_limit();
            int lim;
            lim = limit_val;
            if (lim > LEN_CAP) lim = LEN_CAP;
            if (lim > FRAME_DEPTH_DEFAULT - 3) lim = FRAME_DEPTH_DEFAULT - 3;
            return lim;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_SYNC:  sync_val  = value[7:0];
                REG_END:   end_val   = value[7:0];
                REG_LIMIT: limit_val = value[4:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(t_reg_idx idx);
            case (idx)
                REG_SYNC:  return {24'd0, sync_val};
                REG_END:   return {24'd0, end_val};
                REG_LIMIT: return {27'd0, limit_val};
                default:   return 32'd0;
            endcase
        endfunction

        function void push_result(logic [7:0] fb, int idx, t_status st, logic last);
            t_result r;
            r.frame_byte = fb;
            r.byte_index = idx[4:0];
            r.status     = st;
            r.is_last    = last;
            replay_queue.push_back(r);
        endfunction

        // Advance the frame hunt by one accepted byte and queue what it yields
        function void absorb_byte(logic [7:0] b, logic start);
            int      count;
            t_status st;
            if (start) rearm_hunt();
            if (hunt_pos == 0) begin
                if (b == sync_val) begin
                    hunt_pos  = 1;
                    check_acc = 8'h00;
                end
                return;
            end
            if (hunt_pos == 1) begin
                if (int'(b) > eff_limit()) bytes_due = 2;
                else bytes_due = int'(b) + 1;
                check_acc = b;
                hunt_pos  = 2;
                return;
            end
            if (bytes_due > 2) begin
                if (hunt_pos - 2 < FRAME_DEPTH_DEFAULT) store[hunt_pos - 2] = b;
                check_acc = check_acc ^ b;
                hunt_pos  = (hunt_pos + 1) & 31;
                bytes_due--;
                return;
            end
            if (bytes_due == 2) begin
                check_acc = check_acc ^ b;
                hunt_pos  = (hunt_pos + 1) & 31;
                bytes_due--;
                return;
            end
            if (bytes_due == 1) begin
                count = (hunt_pos >= 4) ? hunt_pos - 3 : 0;
                if (count == 0) st = ST_TOO_SHORT;
                else if (check_acc != 8'h00) st = ST_CHECKSUM;
                else if (b != end_val) st = ST_BAD_END;
                else st = ST_GOOD;
                if (st != ST_GOOD) begin
                    push_result(8'h00, 0, st, 1'b1);
                end else begin
                    for (int k = 0; k < count && k < FRAME_DEPTH_DEFAULT; k++)
                        push_result(store[k], k, ST_GOOD, (k + 1 == count));
                end
            end
            rearm_hunt();
        endfunction

        // Compare one accepted result with the oldest queued one
        function void check_result(t_result got);
            t_result want;
            if (replay_queue.size() == 0) begin
                $error("unexpected result: frame_byte %0h byte_index %0d status %0d",
                       got.frame_byte, got.byte_index, got.status);
                mismatches++;
                return;
            end
            want = replay_queue.pop_front();
            if (got.frame_byte !== want.frame_byte) begin
                $error("frame_byte: expected %0h, got %0h", want.frame_byte, got.frame_byte);
                mismatches++;
            end
            if (got.byte_index !== want.byte_index) begin
                $error("byte_index: expected %0d, got %0d", want.byte_index, got.byte_index);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.is_last !== want.is_last) begin
                $error("is_last: expected %0d, got %0d", want.is_last, got.is_last);
                mismatches++;
            end
        endfunction
    endclass
endpackage

module xor_checked_frame_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import xcfr_pkg::*;
    import xcfr_tb_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte;
    logic        i_packet_start;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_frame_byte;
    logic [4:0]  o_byte_index;
    logic [1:0]  o_status;
    logic        o_is_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    frame_deframer_model model = new();
    bit idle_on     = 1'b1;
    bit force_start = 1'b0;
    int bytes_sent  = 0;

    xor_checked_frame_receiver i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .i_packet_start (i_packet_start),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_frame_byte   (o_frame_byte),
        .o_byte_index   (o_byte_index),
        .o_status       (o_status),
        .o_is_last      (o_is_last),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #1 i_clk = ~i_clk;

    // Stall the result side at random unless idling is switched off
    always @(negedge i_clk) begin
        i_out_stall = idle_on ? ($urandom_range(99) < 26) : 1'b0;
    end

    // Check every accepted result request
    always @(posedge i_clk) begin : result_monitor
        t_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.frame_byte = o_frame_byte;
            got.byte_index = o_byte_index;
            got.status     = t_status'(o_status);
            got.is_last    = o_is_last;
            model.check_result(got);
        end
    end

    // Offer one byte, hold it until taken, then note it in the predictor
    task automatic push_byte(input logic [7:0] b, input logic start);
        while (idle_on && $urandom_range(99) < 26) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_rx_byte      = b;
        i_packet_start = start;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        model.absorb_byte(b, start);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Drop valid and hold off until every queued result has arrived
    task automatic drain_results(input int extra);
        i_in_valid = 1'b0;
        while (model.replay_queue.size() != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        model.set_reg(idx, value);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read_check(input t_reg_idx idx);
        psel    = 1'b1;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== model.reg_value(idx)) begin
            $error("prdata: expected %0h, got %0h", model.reg_value(idx), prdata);
            model.mismatches++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic confirm_regs();
        apb_read_check(REG_SYNC);
        apb_read_check(REG_END);
        apb_read_check(REG_LIMIT);
    endtask

    // Reprogram all registers with the block idle, then read them back
    task automatic set_regs(input logic [7:0] s, input logic [7:0] e, input logic [4:0] l);
        drain_results(40);
        apb_write(REG_SYNC, {24'd0, s});
        apb_write(REG_END, {24'd0, e});
        apb_write(REG_LIMIT, {27'd0, l});
        confirm_regs();
    endtask

    // Feed up to two bytes between frames; avoid the sync value
    task automatic push_noise();
        int         n;
        logic [7:0] b;
        n = $urandom_range(0, 2);
        repeat (n) begin
            b = 8'($urandom_range(255));
            if (b == model.sync_val) b = b ^ 8'h01;
            push_byte(b, 1'($urandom_range(1)));
        end
    endtask

    // Build one frame with random content; optionally cut it short
    task automatic send_frame(input bit truncate);
        int         len;
        int         lim;
        int         r;
        int         cut;
        logic [7:0] acc;
        logic [7:0] content;
        logic [7:0] seq [$];
        lim = model.eff_limit();
        r   = $urandom_range(99);
        if (r < 10) len = lim;
        else if (r < 65) len = $urandom_range(0, 8);
        else if (r < 85) len = $urandom_range(9, 31);
        else len = $urandom_range(32, 255);
        seq.push_back(model.sync_val);
        seq.push_back(len[7:0]);
        acc = len[7:0];
        if (len > lim) begin
            seq.push_back(8'($urandom_range(255)));
        end else if (len > 0) begin
            for (int k = 0; k < len - 1; k++) begin
                content = 8'($urandom_range(255));
                acc     = acc ^ content;
                seq.push_back(content);
            end
            seq.push_back(($urandom_range(99) < 88) ? acc : acc ^ 8'($urandom_range(1, 255)));
        end
        seq.push_back(($urandom_range(99) < 88) ? model.end_val : 8'($urandom_range(255)));
        cut = truncate ? $urandom_range(1, seq.size() - 1) : seq.size();
        for (int k = 0; k < cut; k++)
            push_byte(seq[k], (k == 0) && (force_start || $urandom_range(3) == 0));
        force_start = truncate;
    endtask

    task automatic run_random(input int count);
        int stop;
        int r;
        stop = bytes_sent + count;
        while (bytes_sent < stop) begin
            r = $urandom_range(99);
            if (r < 4) drain_results(0);
            push_noise();
            send_frame(r >= 4 && r < 14);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_rx_byte      = 8'h00;
        i_packet_start = 1'b0;
        i_out_stall    = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = 4'd0;
        pwdata         = 32'd0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        confirm_regs();

        // Directed: ignored noise, good frame, short, clamped, bad checksum, bad end
        push_byte(8'hFF, 1'b1);
        push_byte(SYNC_RESET, 1'b0); push_byte(8'h02, 1'b0); push_byte(8'hFF, 1'b0);
        push_byte(8'hFD, 1'b0); push_byte(END_RESET, 1'b0);
        push_byte(SYNC_RESET, 1'b0); push_byte(8'h00, 1'b0); push_byte(END_RESET, 1'b0);
        push_byte(SYNC_RESET, 1'b0); push_byte(8'h19, 1'b0); push_byte(8'h00, 1'b0);
        push_byte(END_RESET, 1'b0);
        push_byte(SYNC_RESET, 1'b0); push_byte(8'h03, 1'b0); push_byte(8'h10, 1'b0);
        push_byte(8'h20, 1'b0); push_byte(8'h00, 1'b0); push_byte(END_RESET, 1'b0);
        push_byte(SYNC_RESET, 1'b0); push_byte(8'h02, 1'b0); push_byte(8'h55, 1'b0);
        push_byte(8'h57, 1'b0); push_byte(8'h00, 1'b0);
        // Restart a half-received frame with a packet start on a fresh sync
        push_byte(SYNC_RESET, 1'b0); push_byte(8'h05, 1'b0); push_byte(8'h12, 1'b0);
        push_byte(SYNC_RESET, 1'b1); push_byte(8'h02, 1'b0); push_byte(8'h7F, 1'b0);
        push_byte(8'h7D, 1'b0); push_byte(END_RESET, 1'b0);
        drain_results(0);
        run_random(45);

        set_regs(8'h00, 8'hFF, 5'd31);
        run_random(45);

        // Full-rate stretch with no idling on either side
        set_regs(8'hFF, 8'h00, 5'd1);
        idle_on = 1'b0;
        run_random(35);
        idle_on = 1'b1;

        set_regs(8'($urandom_range(255)), 8'($urandom_range(255)), 5'd0);
        run_random(20);

        set_regs(8'h5A, 8'hA5, 5'd29);
        run_random(45);

        drain_results(40);
        if (model.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Abort a hung run
    initial begin
        #200000;
        $display("FAILURE");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/xcfr_pkg.sv
hdl/xor_checked_frame_receiver.sv
tb/xor_checked_frame_receiver_tb.sv
